// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the join table block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define RJHT_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define RJHT_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define RJHT_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: src/rjht_pkg.sv
// ----------------------------------------------------------------------------
// Join table package
// Types, codes and sizes shared by the join handshake table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rjht_pkg;

	localparam int TableDepth = 8;
	localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;

	localparam int AddrW  = 40;
	localparam int TimeW  = 32;
	localparam int TmoW   = 16;
	localparam int CountW = 8;

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] CFG_JOIN_TIMEOUT      = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_CONFIRM_THRESHOLD = 2'd1;

	localparam logic [TmoW-1:0]   JOIN_TIMEOUT_RESET      = 16'd60;
	localparam logic [CountW-1:0] CONFIRM_THRESHOLD_RESET = 8'd16;
	localparam logic [CountW-1:0] COUNT_MAX               = 8'd255;

	localparam logic [7:0] PKT_TYPE_DISCOVERY = 8'd5;
	localparam logic [5:0] MIN_PKT_LENGTH     = 6'd12;

	localparam logic [7:0] STEP_REQUEST = 8'd1;
	localparam logic [7:0] STEP_CONFIRM = 8'd3;
	localparam logic [7:0] STEP_CHECK   = 8'd4;
	localparam logic [7:0] STEP_FINISH  = 8'd6;

	localparam logic [2:0] REPLY_NONE   = 3'd0;
	localparam logic [2:0] REPLY_JOIN   = 3'd2;
	localparam logic [2:0] REPLY_ACCEPT = 3'd5;
	localparam logic [2:0] REPLY_DONE   = 3'd7;

	typedef enum logic [1:0] {
		OUTCOME_REPLY       = 2'd0,
		OUTCOME_TABLE_FULL  = 2'd1,
		OUTCOME_LOW_QUALITY = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [7:0]       packet_type;
		logic [5:0]       packet_length;
		logic [7:0]       progress_step;
		logic [AddrW-1:0] source_address;
		logic [TimeW-1:0] now_seconds;
	} pkt_t;

	typedef struct packed {
		outcome_t         outcome;
		logic [2:0]       reply_code;
		logic [AddrW-1:0] reply_address;
		logic             add_forwarding;
	} res_t;

	// One table entry as seen by the comparator.
	typedef struct packed {
		logic             valid;
		logic [AddrW-1:0] address;
		logic [TimeW-1:0] start_time;
	} slot_view_t;

	// Verdict of the comparator on one entry.
	typedef struct packed {
		logic stale;
		logic hit;
		logic free;
	} slot_verdict_t;

endpackage

`default_nettype wire

// File: src/radio_join_handshake_table_unit.sv
// ----------------------------------------------------------------------------
// Radio join handshake table
// Tracks nodes joining over discovery packets and issues join replies.
// ----------------------------------------------------------------------------
//
//   channel | signals                          | handshake
//   --------+----------------------------------+------------------------------
//   pkt     | pkt_valid, pkt_stall, pkt        | taken when valid and !stall
//   res     | res_valid, res_stall, res        | taken when valid and !stall
//   cfg     | cfg_valid, cfg_ready, cfg_index, | written when valid and ready
//           | cfg_data                         |
//
// A discovery word passes through the accept cycle, a scan that steps
// through every entry in turn with the single age and address comparator,
// and the action cycle. Any other word is dropped in its accept cycle.
// Reset clears all entry valid bits at once and restores register defaults.
// The action cycle waits while a previous result is still stalled on res.
//
`default_nettype none

module radio_join_handshake_table_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 pkt_valid,
	output logic                                pkt_stall,
	input  wire rjht_pkg::pkt_t                 pkt,
	output logic                                res_valid,
	input  wire                                 res_stall,
	output rjht_pkg::res_t                      res,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rjht_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [rjht_pkg::CfgDataW-1:0]  cfg_data
);

`include "assert_macros.svh"

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_ACT  = 3'b100
	} state_t;

	state_t state_q;

	logic [rjht_pkg::TmoW-1:0]   timeout_q;
	logic [rjht_pkg::CountW-1:0] threshold_q;

	logic [rjht_pkg::TableDepth-1:0] slot_valid_q;
	logic [rjht_pkg::AddrW-1:0]      slot_addr_q   [rjht_pkg::TableDepth];
	logic [rjht_pkg::TimeW-1:0]      slot_start_q  [rjht_pkg::TableDepth];
	logic                            slot_acc_q    [rjht_pkg::TableDepth];
	logic [rjht_pkg::CountW-1:0]     slot_count_q  [rjht_pkg::TableDepth];

	rjht_pkg::pkt_t          pkt_q;
	logic [rjht_pkg::IdxW-1:0] scan_idx_q;
	logic                    hit_found_q;
	logic [rjht_pkg::IdxW-1:0] hit_idx_q;
	logic                    free_found_q;
	logic [rjht_pkg::IdxW-1:0] free_idx_q;

	logic           res_valid_q;
	rjht_pkg::res_t res_q;

	rjht_pkg::slot_view_t    scan_view;
	rjht_pkg::slot_verdict_t verdict;

	logic pkt_fire;
	logic pkt_wanted;
	logic scan_last;
	logic act_fire;

	logic                      act_emit;
	rjht_pkg::res_t            act_res;
	logic                      act_wr_new;
	logic                      act_free;
	logic                      act_set_acc;
	logic                      act_bump;
	logic [rjht_pkg::IdxW-1:0] act_idx;
	logic                      hit_acc;
	logic [rjht_pkg::CountW-1:0] hit_count;

	assign pkt_stall = (state_q != ST_IDLE);
	assign pkt_fire  = pkt_valid & ~pkt_stall;
	assign pkt_wanted = (pkt.packet_type == rjht_pkg::PKT_TYPE_DISCOVERY) &&
		(pkt.packet_length >= rjht_pkg::MIN_PKT_LENGTH);
	assign scan_last = (scan_idx_q == rjht_pkg::IdxW'(rjht_pkg::TableDepth - 1));
	assign act_fire  = (state_q == ST_ACT) & (~res_valid_q | ~res_stall);

	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign scan_view.valid      = slot_valid_q[scan_idx_q];
	assign scan_view.address    = slot_addr_q[scan_idx_q];
	assign scan_view.start_time = slot_start_q[scan_idx_q];

	rjht_slot_cmp u_cmp (
		.slot        (scan_view),
		.address     (pkt_q.source_address),
		.now_seconds (pkt_q.now_seconds),
		.timeout     (timeout_q),
		.verdict     (verdict)
	);

	assign hit_acc   = slot_acc_q[hit_idx_q];
	assign hit_count = slot_count_q[hit_idx_q];

	// Decide what the action cycle does with the table and the result.
	always_comb begin
		act_emit    = 1'b0;
		act_wr_new  = 1'b0;
		act_free    = 1'b0;
		act_set_acc = 1'b0;
		act_bump    = 1'b0;
		act_idx     = hit_found_q ? hit_idx_q : free_idx_q;
		act_res.outcome        = rjht_pkg::OUTCOME_REPLY;
		act_res.reply_code     = rjht_pkg::REPLY_NONE;
		act_res.reply_address  = pkt_q.source_address;
		act_res.add_forwarding = 1'b0;
		unique case (pkt_q.progress_step)
			rjht_pkg::STEP_REQUEST: begin
				act_emit = 1'b1;
				if (hit_found_q || free_found_q) begin
					act_wr_new         = 1'b1;
					act_res.reply_code = rjht_pkg::REPLY_JOIN;
				end else begin
					act_res.outcome = rjht_pkg::OUTCOME_TABLE_FULL;
				end
			end
			rjht_pkg::STEP_CONFIRM: begin
				act_bump = hit_found_q & ~hit_acc & (hit_count != rjht_pkg::COUNT_MAX);
			end
			rjht_pkg::STEP_CHECK: begin
				act_emit = hit_found_q;
				if (hit_count >= threshold_q) begin
					act_set_acc        = hit_found_q;
					act_res.reply_code = rjht_pkg::REPLY_ACCEPT;
				end else begin
					act_res.outcome = rjht_pkg::OUTCOME_LOW_QUALITY;
				end
			end
			rjht_pkg::STEP_FINISH: begin
				act_emit               = hit_found_q & hit_acc;
				act_free               = hit_found_q & hit_acc;
				act_res.reply_code     = rjht_pkg::REPLY_DONE;
				act_res.add_forwarding = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			timeout_q    <= rjht_pkg::JOIN_TIMEOUT_RESET;
			threshold_q  <= rjht_pkg::CONFIRM_THRESHOLD_RESET;
			slot_valid_q <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					rjht_pkg::CFG_JOIN_TIMEOUT:      timeout_q   <= cfg_data;
					rjht_pkg::CFG_CONFIRM_THRESHOLD: threshold_q <= cfg_data[rjht_pkg::CountW-1:0];
					default: begin
					end
				endcase
			end

			// A new result may replace one that is being taken in the same cycle.
			if (act_fire && act_emit) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (pkt_fire && pkt_wanted) begin
						state_q      <= ST_SCAN;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					// Purge and lookup share one pass: an entry is judged after its own purge.
					if (verdict.stale) begin
						slot_valid_q[scan_idx_q] <= 1'b0;
					end
					if (verdict.hit && !hit_found_q) begin
						hit_found_q <= 1'b1;
					end
					if (verdict.free && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (scan_last) begin
						state_q <= ST_ACT;
					end
				end
				ST_ACT: begin
					if (act_fire) begin
						state_q <= ST_IDLE;
						if (act_wr_new) begin
							slot_valid_q[act_idx] <= 1'b1;
						end
						if (act_free) begin
							slot_valid_q[hit_idx_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers and entry contents need no reset.
	always_ff @(posedge clk) begin
		if (pkt_fire) begin
			pkt_q      <= pkt;
			scan_idx_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			scan_idx_q <= scan_idx_q + rjht_pkg::IdxW'(1);
			if (verdict.hit && !hit_found_q) begin
				hit_idx_q <= scan_idx_q;
			end
			if (verdict.free && !free_found_q) begin
				free_idx_q <= scan_idx_q;
			end
		end
		if (act_fire) begin
			if (act_emit) begin
				res_q <= act_res;
			end
			if (act_wr_new) begin
				slot_addr_q[act_idx]  <= pkt_q.source_address;
				slot_start_q[act_idx] <= pkt_q.now_seconds;
				slot_acc_q[act_idx]   <= 1'b0;
				slot_count_q[act_idx] <= '0;
			end
			if (act_set_acc) begin
				slot_acc_q[hit_idx_q] <= 1'b1;
			end
			if (act_bump) begin
				slot_count_q[hit_idx_q] <= hit_count + rjht_pkg::CountW'(1);
			end
		end
	end

	// A matched entry is still live when the action cycle uses it.
	`RJHT_ASSERT_SAME(a_hit_live, (state_q == ST_ACT) && hit_found_q, slot_valid_q[hit_idx_q], "matched entry is not valid in the action cycle")

	// A finish that forwards a node frees its entry.
	`RJHT_ASSERT_NEXT(a_finish_frees, act_fire && act_free, !slot_valid_q[$past(hit_idx_q)], "forwarded entry was not freed")

	// A new result word only ever comes out of the action cycle.
	`RJHT_ASSERT_SAME(a_res_source, $rose(res_valid_q), $past(act_fire && act_emit), "result raised outside the action cycle")

	// Forwarding goes only with the finish reply.
	`RJHT_ASSERT_ALWAYS(a_fwd_code, !res_valid_q || !res_q.add_forwarding || (res_q.reply_code == rjht_pkg::REPLY_DONE), "forwarding flag without finish reply")

endmodule

`default_nettype wire

// File: src/rjht_slot_cmp.sv
// ----------------------------------------------------------------------------
// Join table entry comparator
// Ages one entry against the timeout and matches its address.
// ----------------------------------------------------------------------------
`default_nettype none

module rjht_slot_cmp (
	input  wire rjht_pkg::slot_view_t          slot,
	input  wire logic [rjht_pkg::AddrW-1:0]    address,
	input  wire logic [rjht_pkg::TimeW-1:0]    now_seconds,
	input  wire logic [rjht_pkg::TmoW-1:0]     timeout,
	output rjht_pkg::slot_verdict_t            verdict
);

	logic [rjht_pkg::TimeW-1:0] age;
	logic                       too_old;

	// The age wraps with the clock, so a plain modular subtraction is right.
	assign age     = now_seconds - slot.start_time;
	assign too_old = age > {{(rjht_pkg::TimeW - rjht_pkg::TmoW){1'b0}}, timeout};

	assign verdict.stale = slot.valid & too_old;
	assign verdict.hit   = slot.valid & ~too_old & (slot.address == address);
	assign verdict.free  = ~slot.valid | too_old;

endmodule

`default_nettype wire
